// ----- src/signed_int_to_decimal_ascii_defines.svh -----
// Assertion macros shared by the signed_int_to_decimal_ascii RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef SYNTHESIS
`define SIDTA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sidta assertion failed");
`define SIDTA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("sidta forbidden condition seen");
`else
`define SIDTA_ASSERT(lbl, clk, rst_n, prop)
`define SIDTA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- src/sidta_pkg.sv -----
// Shared types and constants for the signed integer to decimal ASCII block.
// No dependencies.
package sidta_pkg;

	localparam int VALUE_BITS = 32;
	// decimal digits needed for a VALUE_BITS-bit magnitude (log10(2) ~ 0.30103)
	localparam int DIGITS     = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W      = 4 * DIGITS;
	localparam int DIG_IDX_W  = $clog2(DIGITS);
	localparam int CNT_W      = $clog2(VALUE_BITS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_MINUS = 6'd45;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_CONV,
		FS_PUSH
	} front_state_t;

	// one converted number waiting for emission
	typedef struct packed {
		logic                 neg;
		logic [BCD_W-1:0]     bcd;
		logic [DIG_IDX_W-1:0] top;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

// ----- src/sidta_fifo.sv -----
// Two-entry queue of converted numbers between front and back.
// Depends on sidta_pkg and signed_int_to_decimal_ascii_defines.svh.
`include "signed_int_to_decimal_ascii_defines.svh"
module sidta_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sidta_pkg::entry_t   wr_data,
	input  logic                pop,
	output sidta_pkg::entry_t   rd_data,
	output sidta_pkg::fifo_stat_t stat
);
	import sidta_pkg::*;

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_data;
	end

	assign rd_data    = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	`SIDTA_ASSERT(a_no_pop_empty, clk, arst_n, pop |-> count_q != '0)
	`SIDTA_ASSERT(a_no_push_full, clk, arst_n, push |-> count_q != QCNT_W'(QUEUE_DEPTH))
	`SIDTA_ASSERT_NEVER(a_count_range, clk, arst_n, count_q > QCNT_W'(QUEUE_DEPTH))

endmodule

// ----- src/sidta_front.sv -----
// Front end: accepts a request, forms sign and magnitude, converts to BCD
// one bit per cycle (shift and add-3), finds the top digit, queues the result.
// Depends on sidta_pkg.
module sidta_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [sidta_pkg::VALUE_BITS-1:0] value,
	output logic                                busy,
	input  sidta_pkg::fifo_stat_t               fifo_stat,
	output logic                                push,
	output sidta_pkg::entry_t                   push_data
);
	import sidta_pkg::*;

	front_state_t          state_q, state_d;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic                  neg_q;

	logic [VALUE_BITS-1:0] value_u;
	logic [BCD_W-1:0]      bcd_adj;
	logic [DIG_IDX_W-1:0]  top;
	logic                  accept;

	assign value_u = value;
	assign accept  = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FS_IDLE: if (start) state_d = FS_CONV;
			FS_CONV: if (cnt_q == '0) state_d = FS_PUSH;
			FS_PUSH: if (!fifo_stat.full) state_d = FS_IDLE;
			default: state_d = FS_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		push = 1'b0;
		case (state_q)
			FS_IDLE: busy = 1'b0;
			FS_CONV: busy = 1'b1;
			FS_PUSH: push = !fifo_stat.full;
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= CNT_W'(VALUE_BITS - 1);
			else if (state_q == FS_CONV && cnt_q != '0) cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			else                          bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= value_u[VALUE_BITS-1];
			mag_q <= value_u[VALUE_BITS-1] ? (~value_u + VALUE_BITS'(1)) : value_u;
			bcd_q <= '0;
		end else if (state_q == FS_CONV) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], mag_q[VALUE_BITS-1]};
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// highest nonzero digit; zero leaves index 0 so a single '0' goes out
	always_comb begin
		top = '0;
		for (int i = 1; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] != 4'd0) top = DIG_IDX_W'(i);
		end
	end

	assign push_data.neg = neg_q;
	assign push_data.bcd = bcd_q;
	assign push_data.top = top;

endmodule

// ----- src/sidta_back.sv -----
// Back end: takes converted numbers from the queue and emits one ASCII
// character per cycle, sign first, then digits from the top one down.
// Depends on sidta_pkg and signed_int_to_decimal_ascii_defines.svh.
`include "signed_int_to_decimal_ascii_defines.svh"
module sidta_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sidta_pkg::fifo_stat_t fifo_stat,
	input  sidta_pkg::entry_t     rd_data,
	output logic                  pop,
	output logic                  strobe,
	output logic [5:0]            char_code,
	output logic                  is_last
);
	import sidta_pkg::*;

	logic                 active_q;
	logic                 sign_q;
	logic [DIG_IDX_W-1:0] idx_q;
	logic [BCD_W-1:0]     bcd_q;
	logic                 strobe_q;
	logic [5:0]           char_code_q;
	logic                 is_last_q;

	logic                 emit_last;
	logic [3:0]           digit;

	assign emit_last = active_q && !sign_q && (idx_q == '0);
	assign pop       = !fifo_stat.empty && (!active_q || emit_last);
	assign digit     = bcd_q[{idx_q, 2'b00} +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			sign_q   <= 1'b0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				sign_q   <= rd_data.neg;
				idx_q    <= rd_data.top;
			end else if (active_q) begin
				if (sign_q)            sign_q   <= 1'b0;
				else if (idx_q == '0)  active_q <= 1'b0;
				else                   idx_q    <= idx_q - DIG_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) bcd_q <= rd_data.bcd;
		char_code_q <= sign_q ? CHAR_MINUS : (CHAR_ZERO + {2'b00, digit});
		is_last_q   <= emit_last;
	end

	assign strobe    = strobe_q;
	assign char_code = char_code_q;
	assign is_last   = is_last_q;

	`SIDTA_ASSERT(a_sign_not_last, clk, arst_n,
		strobe_q && char_code_q == CHAR_MINUS |-> !is_last_q)
	`SIDTA_ASSERT(a_sign_then_digit, clk, arst_n,
		strobe_q && char_code_q == CHAR_MINUS |=> strobe_q && char_code_q != CHAR_MINUS)
	`SIDTA_ASSERT(a_chars_contiguous, clk, arst_n, strobe_q && !is_last_q |=> strobe_q)

endmodule

// ----- src/signed_int_to_decimal_ascii.sv -----
// Top level of the signed integer to decimal ASCII converter.
// Depends on sidta_pkg, sidta_front, sidta_fifo and sidta_back.
//
// A request is taken when start is high and busy is low. The front end runs
// its one-bit-per-cycle binary-to-BCD loop over all VALUE_BITS (32) bits,
// then queues the result; busy is high from each request until its result is
// queued, and stays high while the two-entry queue is full, so a new request
// is taken only after the last one is queued. Characters leave one per cycle
// on char_code with strobe high for exactly one cycle each, minus sign first,
// most significant digit first, no leading zeros, is_last high on the final
// digit. The first character reaches char_code from the queue through the
// back end's output registers. The receiver cannot stall the output.
module signed_int_to_decimal_ascii (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [sidta_pkg::VALUE_BITS-1:0] value,
	output logic                                   strobe,
	output logic [5:0]                             char_code,
	output logic                                   is_last
);
	import sidta_pkg::*;

	fifo_stat_t fifo_stat;
	entry_t     push_data;
	entry_t     rd_data;
	logic       push;
	logic       pop;

	sidta_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.fifo_stat (fifo_stat),
		.push      (push),
		.push_data (push_data)
	);

	sidta_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (push_data),
		.pop     (pop),
		.rd_data (rd_data),
		.stat    (fifo_stat)
	);

	sidta_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.rd_data   (rd_data),
		.pop       (pop),
		.strobe    (strobe),
		.char_code (char_code),
		.is_last   (is_last)
	);

endmodule
